[rtl/rspc_pkg.sv]
// Shared types, constants and the arctangent table for the range scan
// polar-to-cartesian converter. No dependencies; used by every other file.
`default_nettype none

package rspc_pkg;

	// Scan geometry
	localparam int MAX_SCAN_SAMPLES = 4096;
	localparam int IDX_W            = $clog2(MAX_SCAN_SAMPLES);
	localparam int BEAM_W           = 12;

	// Field widths
	localparam int RANGE_W = 32;
	localparam int ANGLE_W = 32;
	localparam int COORD_W = 33;
	localparam int TDATA_OUT_W = 80;
	localparam int CFG_IDX_W = 8;

	// CORDIC datapath: Q16.16 plus 8 guard bits, with headroom for the gain
	localparam int CORDIC_STEPS = 32;
	localparam int STEP_W       = $clog2(CORDIC_STEPS);
	localparam int XW           = 44;
	localparam int GUARD_BITS   = 8;
	localparam int RND_W        = XW - GUARD_BITS;
	localparam int NEG_W        = RND_W + 1;

	// CORDIC gain 0.60725... in Q32
	localparam logic [31:0] GAIN_Q32 = 32'd2608131496;

	// Saturation bounds of a coordinate, in the width after negation
	localparam logic signed [NEG_W-1:0] POS_LIMIT = NEG_W'(64'sd4294967295);
	localparam logic signed [NEG_W-1:0] NEG_LIMIT = NEG_W'(-64'sd4294967295);

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_START = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP  = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW   = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH  = 8'd3;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_MULR  = 7'b0000010,
		ST_MULA  = 7'b0000100,
		ST_ANGLE = 7'b0001000,
		ST_ROT   = 7'b0010000,
		ST_ROUND = 7'b0100000,
		ST_EMIT  = 7'b1000000
	} state_t;

	// atan(2^-i) in binary-angle units, 2^32 per turn
	function automatic logic [ANGLE_W-1:0] atan_lut(input logic [STEP_W-1:0] i);
		logic [ANGLE_W-1:0] a;
		unique case (i)
			5'd0:  a = 32'h20000000;
			5'd1:  a = 32'h12E4051E;
			5'd2:  a = 32'h09FB385B;
			5'd3:  a = 32'h051111D4;
			5'd4:  a = 32'h028B0D43;
			5'd5:  a = 32'h0145D7E1;
			5'd6:  a = 32'h00A2F61E;
			5'd7:  a = 32'h00517C55;
			5'd8:  a = 32'h0028BE53;
			5'd9:  a = 32'h00145F2F;
			5'd10: a = 32'h000A2F98;
			5'd11: a = 32'h000517CC;
			5'd12: a = 32'h00028BE6;
			5'd13: a = 32'h000145F3;
			5'd14: a = 32'h0000A2FA;
			5'd15: a = 32'h0000517D;
			5'd16: a = 32'h000028BE;
			5'd17: a = 32'h0000145F;
			5'd18: a = 32'h00000A30;
			5'd19: a = 32'h00000518;
			5'd20: a = 32'h0000028C;
			5'd21: a = 32'h00000146;
			5'd22: a = 32'h000000A3;
			5'd23: a = 32'h00000051;
			5'd24: a = 32'h00000029;
			5'd25: a = 32'h00000014;
			5'd26: a = 32'h0000000A;
			5'd27: a = 32'h00000005;
			5'd28: a = 32'h00000003;
			5'd29: a = 32'h00000001;
			5'd30: a = 32'h00000001;
			default: a = 32'h00000000;
		endcase
		return a;
	endfunction

	// Clamp a coordinate to +/-(2^32-1) and cut it to the output width
	function automatic logic signed [COORD_W-1:0] sat_coord(
		input logic signed [NEG_W-1:0] v);
		logic signed [NEG_W-1:0] c;
		if (v > POS_LIMIT) begin
			c = POS_LIMIT;
		end else if (v < NEG_LIMIT) begin
			c = NEG_LIMIT;
		end else begin
			c = v;
		end
		return c[COORD_W-1:0];
	endfunction

endpackage

`default_nettype wire

[rtl/range_scan_polar_to_cartesian.sv]
// Top level of the range scan polar-to-cartesian converter: stream ports,
// sequencer, shared multiplier and output register. Uses rspc_pkg, rspc_cordic.
//
// Usage: one range sample (unsigned Q16.16) enters per s_axis transaction,
// tlast marking the last sample of a scan. The beam index counts samples and
// restarts after tlast or after MAX_SCAN_SAMPLES samples. Beam angle is
// angle_start + angle_step * index. A sample inside the inclusive range
// limits gives one m_axis transaction with x, y (signed Q16.16) and the beam
// number; other samples give nothing and the block stays ready for the next.
// An accepted in-range sample occupies the block through its steps: the
// shared 32x32 multiplier (gain scaling, then angle), the quadrant fold, the
// 32 iterations of the CORDIC unit, then rounding and quadrant/saturation.
// s_axis_tready is low meanwhile. The
// result sits in an output register; the next sample is taken while it waits,
// and the block holds at its final step if the receiver still stalls.
// Configuration writes via cfg_* are always taken; indexes above 3 are
// ignored. Reset clears the beam index and sets the registers to their
// defaults (limits 0 and 0xFFFFFFFF).
`default_nettype none

module range_scan_polar_to_cartesian (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    s_axis_tvalid,
	output logic                                         s_axis_tready,
	input  wire logic [rspc_pkg::RANGE_W-1:0]            s_axis_tdata,  // [31:0] range_sample
	input  wire logic                                    s_axis_tlast,  // scan_end
	output logic                                         m_axis_tvalid,
	input  wire logic                                    m_axis_tready,
	// [32:0] point_x, [65:33] point_y, [77:66] beam_number, [79:78] zero
	output logic [rspc_pkg::TDATA_OUT_W-1:0]             m_axis_tdata,
	input  wire logic                                    cfg_valid,
	output logic                                         cfg_ready,
	input  wire logic [rspc_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  wire logic [31:0]                             cfg_data
);

	rspc_pkg::state_t state_q;

	logic [31:0]                      angle_start_q, angle_step_q, range_low_q, range_high_q;
	logic [rspc_pkg::IDX_W-1:0]       idx_q, beam_q;
	logic [rspc_pkg::RANGE_W-1:0]     range_q;
	logic [63:0]                      prod_q, prod, x0_sum;
	logic [31:0]                      mul_a, mul_b;
	logic signed [rspc_pkg::XW-1:0]   x0_q, cx, cy, cx_rnd, cy_rnd;
	logic [rspc_pkg::ANGLE_W-1:0]     angle, angle_bias, z0;
	logic [1:0]                       quad, quad_q;
	logic                             cordic_load, cordic_done;
	logic signed [rspc_pkg::RND_W-1:0] xr_s1, yr_s1;
	logic signed [rspc_pkg::NEG_W-1:0] xe, ye, nxe, nye, qx, qy;
	logic                             in_acc, in_range, out_free;
	logic                             m_valid_q;
	logic [rspc_pkg::TDATA_OUT_W-1:0] m_data_q;

	assign s_axis_tready = (state_q == rspc_pkg::ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign in_range      = (s_axis_tdata >= range_low_q) && (s_axis_tdata <= range_high_q);
	assign out_free      = !m_valid_q || m_axis_tready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_start_q <= '0;
			angle_step_q  <= '0;
			range_low_q   <= '0;
			range_high_q  <= '1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				rspc_pkg::REG_ANGLE_START: angle_start_q <= cfg_data;
				rspc_pkg::REG_ANGLE_STEP:  angle_step_q  <= cfg_data;
				rspc_pkg::REG_RANGE_LOW:   range_low_q   <= cfg_data;
				rspc_pkg::REG_RANGE_HIGH:  range_high_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Shared multiplier: gain scaling first, then the angle offset.
	always_comb begin
		if (state_q == rspc_pkg::ST_MULR) begin
			mul_a = range_q;
			mul_b = rspc_pkg::GAIN_Q32;
		end else begin
			mul_a = angle_step_q;
			mul_b = 32'(beam_q);
		end
	end
	assign prod = mul_a * mul_b;

	assign x0_sum = prod_q + 64'd8388608;

	// Quadrant fold: residual angle lies in [-1/8, 1/8) turn.
	assign angle      = angle_start_q + prod_q[31:0];
	assign angle_bias = angle + 32'h20000000;
	assign quad       = angle_bias[31:30];
	assign z0         = angle - {quad, 30'd0};

	assign cordic_load = (state_q == rspc_pkg::ST_ANGLE);

	rspc_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (cordic_load),
		.x_init (x0_q),
		.z_init (z0),
		.done   (cordic_done),
		.x_out  (cx),
		.y_out  (cy)
	);

	assign cx_rnd = cx + rspc_pkg::XW'(128);
	assign cy_rnd = cy + rspc_pkg::XW'(128);

	assign xe  = {xr_s1[rspc_pkg::RND_W-1], xr_s1};
	assign ye  = {yr_s1[rspc_pkg::RND_W-1], yr_s1};
	assign nxe = -xe;
	assign nye = -ye;

	always_comb begin
		unique case (quad_q)
			2'd0: begin qx = xe;  qy = ye;  end
			2'd1: begin qx = nye; qy = xe;  end
			2'd2: begin qx = nxe; qy = nye; end
			default: begin qx = ye; qy = nxe; end
		endcase
	end

	// Sequencer and beam counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= rspc_pkg::ST_IDLE;
			idx_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (state_q == rspc_pkg::ST_EMIT && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				rspc_pkg::ST_IDLE: begin
					if (in_acc) begin
						if (s_axis_tlast ||
						    idx_q == rspc_pkg::IDX_W'(rspc_pkg::MAX_SCAN_SAMPLES - 1)) begin
							idx_q <= '0;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
						if (in_range) begin
							state_q <= rspc_pkg::ST_MULR;
						end
					end
				end
				rspc_pkg::ST_MULR:  state_q <= rspc_pkg::ST_MULA;
				rspc_pkg::ST_MULA:  state_q <= rspc_pkg::ST_ANGLE;
				rspc_pkg::ST_ANGLE: state_q <= rspc_pkg::ST_ROT;
				rspc_pkg::ST_ROT: begin
					if (cordic_done) begin
						state_q <= rspc_pkg::ST_ROUND;
					end
				end
				rspc_pkg::ST_ROUND: state_q <= rspc_pkg::ST_EMIT;
				rspc_pkg::ST_EMIT: begin
					if (out_free) begin
						state_q <= rspc_pkg::ST_IDLE;
					end
				end
				default: state_q <= rspc_pkg::ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			range_q <= s_axis_tdata;
			beam_q  <= idx_q;
		end
		if (state_q == rspc_pkg::ST_MULR || state_q == rspc_pkg::ST_MULA) begin
			prod_q <= prod;
		end
		if (state_q == rspc_pkg::ST_MULA) begin
			x0_q <= {4'd0, x0_sum[63:24]};
		end
		if (state_q == rspc_pkg::ST_ANGLE) begin
			quad_q <= quad;
		end
		if (state_q == rspc_pkg::ST_ROUND) begin
			xr_s1 <= cx_rnd[rspc_pkg::XW-1:rspc_pkg::GUARD_BITS];
			yr_s1 <= cy_rnd[rspc_pkg::XW-1:rspc_pkg::GUARD_BITS];
		end
		if (state_q == rspc_pkg::ST_EMIT && out_free) begin
			m_data_q <= {2'd0, rspc_pkg::BEAM_W'(beam_q),
			             rspc_pkg::sat_coord(qy), rspc_pkg::sat_coord(qx)};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	// The CORDIC unit finishes only while the sequencer waits for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		cordic_done |-> (state_q == rspc_pkg::ST_ROT))
		else $error("CORDIC finished outside the rotation step");

	// A new result appears only out of the final sequencer step.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == rspc_pkg::ST_EMIT))
		else $error("result raised without a finished conversion");

	// An in-range sample starts a conversion; an out-of-range one does not.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == rspc_pkg::ST_MULR) == $past(in_range))
		else $error("conversion start does not follow the range check");

	// The beam index never reaches the scan length.
	assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= rspc_pkg::IDX_W'(rspc_pkg::MAX_SCAN_SAMPLES - 1))
		else $error("beam index out of range");

endmodule

`default_nettype wire

[rtl/rspc_cordic.sv]
// Iterative rotation-mode CORDIC: one micro-rotation per clock, 32 steps.
// Depends on rspc_pkg for widths and the arctangent table.
`default_nettype none

module rspc_cordic (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                load,
	input  wire logic signed [rspc_pkg::XW-1:0]      x_init,
	input  wire logic [rspc_pkg::ANGLE_W-1:0]        z_init,
	output logic                                     done,
	output logic signed [rspc_pkg::XW-1:0]           x_out,
	output logic signed [rspc_pkg::XW-1:0]           y_out
);

	logic signed [rspc_pkg::XW-1:0]   x_q, y_q, sx, sy;
	logic [rspc_pkg::ANGLE_W-1:0]     z_q, atan_i;
	logic [rspc_pkg::STEP_W-1:0]      step_q;
	logic                             busy_q, done_q, last_step;

	assign sx        = x_q >>> step_q;
	assign sy        = y_q >>> step_q;
	assign atan_i    = rspc_pkg::atan_lut(step_q);
	assign last_step = (step_q == rspc_pkg::STEP_W'(rspc_pkg::CORDIC_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= !load && busy_q && last_step;
			if (load) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (last_step) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Datapath: both updates use the old x and y; the sign of z picks direction.
	always_ff @(posedge clk) begin
		if (load) begin
			x_q <= x_init;
			y_q <= '0;
			z_q <= z_init;
		end else if (busy_q) begin
			if (z_q[rspc_pkg::ANGLE_W-1]) begin
				x_q <= x_q + sy;
				y_q <= y_q - sx;
				z_q <= z_q + atan_i;
			end else begin
				x_q <= x_q - sy;
				y_q <= y_q + sx;
				z_q <= z_q - atan_i;
			end
		end
	end

	assign done  = done_q;
	assign x_out = x_q;
	assign y_out = y_q;

endmodule

`default_nettype wire
